// ----- hw/rtl/apwt_pkg.sv -----
// shared types, constants and term tables for the affine pixel/world transform
`timescale 1ns / 1ps
package apwt_pkg;

	localparam int COORD_WIDTH = 64;
	localparam int NUM_REGS    = 6;
	localparam int ADDR_W      = 6;
	localparam int ACC_W       = 136;
	localparam int R_W         = ACC_W + 2;
	localparam int N_W         = ACC_W + 34;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int HALF_W      = COORD_WIDTH / 2;

	// largest |det| that still counts as singular, in units of 2^-64
	localparam logic [COORD_WIDTH-1:0] DET_EPS_MAX = COORD_WIDTH'(18446744);

	localparam logic CMD_FWD = 1'b0;
	localparam logic CMD_INV = 1'b1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [2:0] {
		REG_ORIGIN_X        = 3'd0,
		REG_PIXEL_WIDTH     = 3'd1,
		REG_ROW_ROTATION    = 3'd2,
		REG_ORIGIN_Y        = 3'd3,
		REG_COLUMN_ROTATION = 3'd4,
		REG_PIXEL_HEIGHT    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		coord_t origin_x;
		coord_t pixel_width;
		coord_t row_rotation;
		coord_t origin_y;
		coord_t column_rotation;
		coord_t pixel_height;
	} coef_t;

	typedef struct packed {
		logic   cmd;
		coord_t a;
		coord_t b;
	} item_t;

	typedef enum logic [2:0] {
		OP_OX = 3'd0,
		OP_GA = 3'd1,
		OP_GB = 3'd2,
		OP_OY = 3'd3,
		OP_GD = 3'd4,
		OP_GE = 3'd5,
		OP_CA = 3'd6,
		OP_CB = 3'd7
	} op_sel_t;

	typedef struct packed {
		op_sel_t sa;
		op_sel_t sb;
		logic    neg;
	} term_t;

	// forward: x = ga*ca + gb*cb, y = gd*ca + ge*cb (origins preloaded)
	// inverse: det, then nx = ge*(ca-ox) - gb*(cb-oy), ny = ga*(cb-oy) - gd*(ca-ox)
	function automatic term_t term_of(logic cmd, logic [1:0] grp, logic [1:0] idx);
		term_t t;
		t = '{sa: OP_GA, sb: OP_CA, neg: 1'b0};
		if (cmd == CMD_FWD) begin
			case ({grp[0], idx[0]})
				2'b00:   t = '{sa: OP_GA, sb: OP_CA, neg: 1'b0};
				2'b01:   t = '{sa: OP_GB, sb: OP_CB, neg: 1'b0};
				2'b10:   t = '{sa: OP_GD, sb: OP_CA, neg: 1'b0};
				default: t = '{sa: OP_GE, sb: OP_CB, neg: 1'b0};
			endcase
		end else begin
			case ({grp, idx})
				4'b0000: t = '{sa: OP_GA, sb: OP_GE, neg: 1'b0};
				4'b0001: t = '{sa: OP_GB, sb: OP_GD, neg: 1'b1};
				4'b0100: t = '{sa: OP_GE, sb: OP_CA, neg: 1'b0};
				4'b0101: t = '{sa: OP_GE, sb: OP_OX, neg: 1'b1};
				4'b0110: t = '{sa: OP_GB, sb: OP_CB, neg: 1'b1};
				4'b0111: t = '{sa: OP_GB, sb: OP_OY, neg: 1'b0};
				4'b1000: t = '{sa: OP_GA, sb: OP_CB, neg: 1'b0};
				4'b1001: t = '{sa: OP_GA, sb: OP_OY, neg: 1'b1};
				4'b1010: t = '{sa: OP_GD, sb: OP_CA, neg: 1'b1};
				4'b1011: t = '{sa: OP_GD, sb: OP_OX, neg: 1'b0};
				default: t = '{sa: OP_GA, sb: OP_GE, neg: 1'b0};
			endcase
		end
		return t;
	endfunction

	// index of the last term in a group
	function automatic logic [1:0] last_term(logic cmd, logic [1:0] grp);
		logic [1:0] r;
		r = 2'd1;
		if (cmd == CMD_INV && grp != 2'd0) begin
			r = 2'd3;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/apwt_in_if.sv -----
// input channel: command and two coordinates
`timescale 1ns / 1ps
interface apwt_in_if;
	logic                  valid;
	logic                  ready;
	logic                  command;
	apwt_pkg::coord_t      coord_a;
	apwt_pkg::coord_t      coord_b;

	modport source (output valid, command, coord_a, coord_b, input ready);
	modport sink (input valid, command, coord_a, coord_b, output ready);
endinterface

// ----- hw/rtl/apwt_out_if.sv -----
// output channel: two coordinates and the singular flag
`timescale 1ns / 1ps
interface apwt_out_if;
	logic                  valid;
	logic                  ready;
	apwt_pkg::coord_t      out_a;
	apwt_pkg::coord_t      out_b;
	logic                  singular;

	modport source (output valid, out_a, out_b, singular, input ready);
	modport sink (input valid, out_a, out_b, singular, output ready);
endinterface

// ----- hw/rtl/apwt_regs.sv -----
// APB register file holding the six transform coefficients
`timescale 1ns / 1ps
module apwt_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [apwt_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	output apwt_pkg::coef_t             coef
);
	import apwt_pkg::*;

	coef_t    coef_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[5:3]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign coef   = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.origin_x        <= '0;
			coef_q.pixel_width     <= coord_t'(64'sh0000_0001_0000_0000);
			coef_q.row_rotation    <= '0;
			coef_q.origin_y        <= '0;
			coef_q.column_rotation <= '0;
			coef_q.pixel_height    <= coord_t'(-64'sh0000_0001_0000_0000);
		end else if (wr_en) begin
			unique case (idx)
				REG_ORIGIN_X:        coef_q.origin_x        <= pwdata;
				REG_PIXEL_WIDTH:     coef_q.pixel_width     <= pwdata;
				REG_ROW_ROTATION:    coef_q.row_rotation    <= pwdata;
				REG_ORIGIN_Y:        coef_q.origin_y        <= pwdata;
				REG_COLUMN_ROTATION: coef_q.column_rotation <= pwdata;
				REG_PIXEL_HEIGHT:    coef_q.pixel_height    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ORIGIN_X:        prdata = coef_q.origin_x;
			REG_PIXEL_WIDTH:     prdata = coef_q.pixel_width;
			REG_ROW_ROTATION:    prdata = coef_q.row_rotation;
			REG_ORIGIN_Y:        prdata = coef_q.origin_y;
			REG_COLUMN_ROTATION: prdata = coef_q.column_rotation;
			REG_PIXEL_HEIGHT:    prdata = coef_q.pixel_height;
			default:             prdata = '0;
		endcase
	end
endmodule

// ----- hw/rtl/apwt_front.sv -----
// front end: takes input transfers, classifies the command and queues items
`timescale 1ns / 1ps
module apwt_front (
	input  logic            clk,
	input  logic            arst_n,
	apwt_in_if.sink         in_ch,
	output logic            q_valid,
	output apwt_pkg::item_t q_item,
	input  logic            q_pop
);
	import apwt_pkg::*;

	item_t             fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              pop;
	item_t             item_in;

	assign in_ch.ready = (cnt_q != (QPTR_W+1)'(QDEPTH));
	assign push        = in_ch.valid & in_ch.ready;
	assign pop         = q_pop & q_valid;
	assign q_valid     = (cnt_q != '0);
	assign q_item      = fifo_q[rd_ptr_q];

	// only bit 0 of the command selects the direction
	assign item_in.cmd = in_ch.command ? CMD_INV : CMD_FWD;
	assign item_in.a   = in_ch.coord_a;
	assign item_in.b   = in_ch.coord_b;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end
endmodule

// ----- hw/rtl/apwt_back.sv -----
// back end: multiply-accumulate over 32x32 partial products, divider and output register
`timescale 1ns / 1ps
module apwt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  apwt_pkg::coef_t coef,
	input  logic            q_valid,
	input  apwt_pkg::item_t q_item,
	output logic            q_pop,
	apwt_out_if.source      out_ch
);
	import apwt_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MUL   = 9'b000000010,
		ST_DRAIN = 9'b000000100,
		ST_GRP   = 9'b000001000,
		ST_DSET  = 9'b000010000,
		ST_DCHK  = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_DEND  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	localparam logic [COORD_WIDTH-1:0] POS_LIM = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] NEG_LIM = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	state_t                   state_q;
	item_t                    item_q;
	logic [1:0]               grp_q;
	logic [1:0]               term_q;
	logic [1:0]               part_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  det_q;
	logic [COORD_WIDTH-1:0]   pp_s1;
	logic [1:0]               pp_shift_s1;
	logic                     pp_neg_s1;
	logic                     pp_v_s1;
	coord_t                   res_a_q;
	coord_t                   res_b_q;
	logic                     sing_q;
	logic                     neg_q;
	logic [R_W-1:0]           d2_q;
	logic [N_W-1:0]           n_q;
	logic [R_W-1:0]           rem_q;
	logic [COORD_WIDTH-1:0]   quo_q;
	logic                     ovf_q;
	logic [5:0]               cnt_q;
	logic                     out_v_q;
	coord_t                   out_a_q;
	coord_t                   out_b_q;
	logic                     out_s_q;

	term_t                    term;
	coord_t                   a_op;
	coord_t                   b_op;
	logic [COORD_WIDTH-1:0]   a_mag;
	logic [COORD_WIDTH-1:0]   b_mag;
	logic [HALF_W-1:0]        a_half;
	logic [HALF_W-1:0]        b_half;
	logic [COORD_WIDTH-1:0]   prod;
	logic [ACC_W-1:0]         pp_ext;
	logic signed [ACC_W-1:0]  acc_add;
	logic [ACC_W-1:0]         acc_mag;
	logic [ACC_W-1:0]         det_mag;
	logic [ACC_W-32-1:0]      rnd_m;
	coord_t                   rnd_val;
	logic [R_W-1:0]           cand;
	logic                     cand_ge;
	coord_t                   div_val;
	logic [COORD_WIDTH-1:0]   lim;
	logic                     slot_free;
	logic                     is_last;

	function automatic coord_t pick(op_sel_t s, coef_t c, item_t it);
		coord_t r;
		case (s)
			OP_OX:   r = c.origin_x;
			OP_GA:   r = c.pixel_width;
			OP_GB:   r = c.row_rotation;
			OP_OY:   r = c.origin_y;
			OP_GD:   r = c.column_rotation;
			OP_GE:   r = c.pixel_height;
			OP_CA:   r = it.a;
			default: r = it.b;
		endcase
		return r;
	endfunction

	// origin in Q.64 for the forward sum
	function automatic logic signed [ACC_W-1:0] origin_q64(coord_t o);
		return {{(ACC_W-COORD_WIDTH-32){o[COORD_WIDTH-1]}}, o, 32'b0};
	endfunction

	always_comb begin
		term   = term_of(item_q.cmd, grp_q, term_q);
		a_op   = pick(term.sa, coef, item_q);
		b_op   = pick(term.sb, coef, item_q);
		a_mag  = a_op[COORD_WIDTH-1] ? (~a_op + 1'b1) : a_op;
		b_mag  = b_op[COORD_WIDTH-1] ? (~b_op + 1'b1) : b_op;
		a_half = part_q[0] ? a_mag[COORD_WIDTH-1:HALF_W] : a_mag[HALF_W-1:0];
		b_half = part_q[1] ? b_mag[COORD_WIDTH-1:HALF_W] : b_mag[HALF_W-1:0];
		prod   = a_half * b_half;
		is_last = (part_q == 2'd3) && (term_q == last_term(item_q.cmd, grp_q));
	end

	always_comb begin
		case (pp_shift_s1)
			2'd0:    pp_ext = ACC_W'(pp_s1);
			2'd1:    pp_ext = ACC_W'(pp_s1) << HALF_W;
			default: pp_ext = ACC_W'(pp_s1) << COORD_WIDTH;
		endcase
		acc_add = pp_neg_s1 ? (acc_q - $signed(pp_ext)) : (acc_q + $signed(pp_ext));
	end

	// forward rounding: half away from zero, then saturate
	always_comb begin
		acc_mag = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;
		det_mag = det_q[ACC_W-1] ? (~det_q + 1'b1) : det_q;
		lim     = acc_q[ACC_W-1] ? NEG_LIM : POS_LIM;
		rnd_m   = (ACC_W-32)'((acc_mag + (ACC_W'(1) << 31)) >> 32);
		if (rnd_m > (ACC_W-32)'(lim)) begin
			rnd_val = lim;
		end else begin
			rnd_val = acc_q[ACC_W-1] ? (~rnd_m[COORD_WIDTH-1:0] + 1'b1) : rnd_m[COORD_WIDTH-1:0];
		end
	end

	always_comb begin
		cand    = {rem_q[R_W-2:0], n_q[COORD_WIDTH-1]};
		cand_ge = (cand >= d2_q);
		if (ovf_q || quo_q > (neg_q ? NEG_LIM : POS_LIM)) begin
			div_val = neg_q ? NEG_LIM : POS_LIM;
		end else begin
			div_val = neg_q ? (~quo_q + 1'b1) : quo_q;
		end
	end

	assign slot_free = !out_v_q || out_ch.ready;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;

	assign out_ch.valid    = out_v_q;
	assign out_ch.out_a    = out_a_q;
	assign out_ch.out_b    = out_b_q;
	assign out_ch.singular = out_s_q;

	always_ff @(posedge clk) begin
		pp_s1       <= prod;
		pp_shift_s1 <= 2'(part_q[0]) + 2'(part_q[1]);
		pp_neg_s1   <= a_op[COORD_WIDTH-1] ^ b_op[COORD_WIDTH-1] ^ term.neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pp_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			pp_v_s1 <= (state_q == ST_MUL);
			if (pp_v_s1) begin
				acc_q <= acc_add;
			end
			if (out_v_q && out_ch.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q  <= q_item;
						grp_q   <= '0;
						term_q  <= '0;
						part_q  <= '0;
						acc_q   <= (q_item.cmd == CMD_FWD) ? origin_q64(coef.origin_x) : '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					part_q <= part_q + 1'b1;
					if (part_q == 2'd3) begin
						term_q <= term_q + 1'b1;
					end
					if (is_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_GRP;
				ST_GRP: begin
					term_q <= '0;
					part_q <= '0;
					if (item_q.cmd == CMD_FWD) begin
						if (grp_q == 2'd0) begin
							res_a_q <= rnd_val;
							grp_q   <= 2'd1;
							acc_q   <= origin_q64(coef.origin_y);
							state_q <= ST_MUL;
						end else begin
							res_b_q <= rnd_val;
							sing_q  <= 1'b0;
							state_q <= ST_DONE;
						end
					end else if (grp_q == 2'd0) begin
						det_q <= acc_q;
						if (acc_mag <= ACC_W'(DET_EPS_MAX)) begin
							res_a_q <= '0;
							res_b_q <= '0;
							sing_q  <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							grp_q   <= 2'd1;
							acc_q   <= '0;
							state_q <= ST_MUL;
						end
					end else begin
						state_q <= ST_DSET;
					end
				end
				ST_DSET: begin
					// quotient = (2|num|*2^32 + |det|) / (2|det|)
					neg_q   <= acc_q[ACC_W-1] ^ det_q[ACC_W-1];
					n_q     <= (N_W'(acc_mag) << 33) + N_W'(det_mag);
					d2_q    <= R_W'(det_mag) << 1;
					state_q <= ST_DCHK;
				end
				ST_DCHK: begin
					ovf_q   <= (R_W'(n_q[N_W-1:COORD_WIDTH]) >= d2_q);
					rem_q   <= R_W'(n_q[N_W-1:COORD_WIDTH]);
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= cand_ge ? (cand - d2_q) : cand;
					quo_q <= {quo_q[COORD_WIDTH-2:0], cand_ge};
					n_q   <= {n_q[N_W-1:COORD_WIDTH], n_q[COORD_WIDTH-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_DEND;
					end
				end
				ST_DEND: begin
					if (grp_q == 2'd1) begin
						res_a_q <= div_val;
						grp_q   <= 2'd2;
						acc_q   <= '0;
						term_q  <= '0;
						part_q  <= '0;
						state_q <= ST_MUL;
					end else begin
						res_b_q <= div_val;
						sing_q  <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						out_v_q <= 1'b1;
						out_a_q <= res_a_q;
						out_b_q <= res_b_q;
						out_s_q <= sing_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hw/rtl/affine_pixel_world_transform.sv -----
// top level of the affine pixel/world transform
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      command, coord_a, coord_b (Q32.32)
//  out_ch    out  valid/ready      out_a, out_b (Q32.32), singular
//  apb       in   psel/penable     six 64-bit coefficients at 8*i
//
// forward item: 16 partial products on one 32x32 multiplier in the back end
// inverse item: 40 partial products plus two 64-step restoring divides
// singular inverse: the divides are skipped
// a four-entry queue takes transfers while the back end works; the output register
// holds a finished result while the next item is already being computed
// reset clears queue pointers, state and valid; coefficients return to identity, north up
`timescale 1ns / 1ps
module affine_pixel_world_transform (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [apwt_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	apwt_in_if.sink                     in_ch,
	apwt_out_if.source                  out_ch
);
	import apwt_pkg::*;

	coef_t coef;
	item_t q_item;
	logic  q_valid;
	logic  q_pop;

	apwt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	apwt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	apwt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.coef    (coef),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);
endmodule

// ----- hw/rtl/apwt_check.sv -----
// port-level checks for the affine pixel/world transform
`timescale 1ns / 1ps
module apwt_check (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input apwt_pkg::coord_t out_a,
	input apwt_pkg::coord_t out_b,
	input logic             singular
);
	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> out_a == '0 && out_b == '0)
		else $error("singular result with nonzero coordinates");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_a) && $stable(out_b))
		else $error("stalled result changed");

	a_reset_quiet: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");
endmodule

bind affine_pixel_world_transform apwt_check u_apwt_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_a     (out_ch.out_a),
	.out_b     (out_ch.out_b),
	.singular  (out_ch.singular)
);

// ----- tb/tb_top.sv -----
// testbench for the affine pixel/world transform: directed table, random items, scoreboard
`timescale 1ns / 1ps
module tb_top;
	import apwt_pkg::*;

	typedef struct {
		logic        cmd;
		logic [63:0] a;
		logic [63:0] b;
	} stim_t;

	typedef struct {
		logic [63:0] oa;
		logic [63:0] ob;
		logic        sing;
	} xform_res_t;

	typedef struct {
		stim_t       s;
		logic        known;
		xform_res_t  r;
	} row_t;

	localparam logic [63:0] MAXP = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] MAXN = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ONE  = 64'h0000_0001_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;

	apwt_in_if  in_ch ();
	apwt_out_if out_ch ();

	affine_pixel_world_transform dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	logic signed [63:0] coef [NUM_REGS];
	xform_res_t pending_results[$];
	int errors = 0;
	int n_items = 0, n_results = 0, n_inv = 0, n_sing = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	logic hold_off = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL affine_pixel_world_transform");
		$finish;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h (result %0d)", what, got, want, n_results);
	endtask

	function automatic logic [63:0] clamp(input logic neg, input logic [255:0] m);
		logic [63:0] lim;
		lim = neg ? MAXN : MAXP;
		if (m > {192'd0, lim}) m = {192'd0, lim};
		return neg ? -m[63:0] : m[63:0];
	endfunction

	function automatic logic [63:0] round_fwd(input logic signed [255:0] acc);
		logic neg;
		logic [255:0] m;
		neg = acc[255];
		m = neg ? -acc : acc;
		m = (m + (256'd1 << 31)) >> 32;
		return clamp(neg, m);
	endfunction

	function automatic logic [63:0] quotient(input logic signed [255:0] num,
			input logic signed [255:0] det);
		logic neg;
		logic [255:0] n, d;
		neg = num[255] ^ det[255];
		n = num[255] ? -num : num;
		d = det[255] ? -det : det;
		n = (n << 33) + d;
		return clamp(neg, n / (d << 1));
	endfunction

	function automatic xform_res_t transform(input stim_t s);
		xform_res_t r;
		logic signed [255:0] ox, ga, gb, oy, gd, ge, ca, cb, det, dx, dy, mag;
		ox = 256'(coef[REG_ORIGIN_X]);
		ga = 256'(coef[REG_PIXEL_WIDTH]);
		gb = 256'(coef[REG_ROW_ROTATION]);
		oy = 256'(coef[REG_ORIGIN_Y]);
		gd = 256'(coef[REG_COLUMN_ROTATION]);
		ge = 256'(coef[REG_PIXEL_HEIGHT]);
		ca = 256'(signed'(s.a));
		cb = 256'(signed'(s.b));
		r.sing = 1'b0;
		if (s.cmd == CMD_FWD) begin
			r.oa = round_fwd((ox <<< 32) + ga * ca + gb * cb);
			r.ob = round_fwd((oy <<< 32) + gd * ca + ge * cb);
		end else begin
			det = ga * ge - gb * gd;
			mag = det[255] ? -det : det;
			if (mag <= 256'(DET_EPS_MAX)) begin
				r.oa = '0;
				r.ob = '0;
				r.sing = 1'b1;
			end else begin
				dx = ca - ox;
				dy = cb - oy;
				r.oa = quotient(ge * dx - gb * dy, det);
				r.ob = quotient(ga * dy - gd * dx, det);
			end
		end
		return r;
	endfunction

	task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ADDR_W'(8 * int'(idx)); pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		coef[idx] = val;
	endtask

	task automatic load_coefs(input logic [63:0] v0, v1, v2, v3, v4, v5);
		reg_write(REG_ORIGIN_X, v0);
		reg_write(REG_PIXEL_WIDTH, v1);
		reg_write(REG_ROW_ROTATION, v2);
		reg_write(REG_ORIGIN_Y, v3);
		reg_write(REG_COLUMN_ROTATION, v4);
		reg_write(REG_PIXEL_HEIGHT, v5);
	endtask

	// one transfer on the input channel, prediction queued at acceptance
	task automatic send(input stim_t s, input logic known, input xform_res_t want);
		xform_res_t p;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.command <= s.cmd;
		in_ch.coord_a <= s.a;
		in_ch.coord_b <= s.b;
		do @(posedge clk); while (!in_ch.ready);
		p = known ? want : transform(s);
		pending_results.insert(pending_results.size(), p);
		n_items++;
		if (s.cmd == CMD_INV) n_inv++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		if (guard >= 200000) begin
			$display("FAIL affine_pixel_world_transform");
			$finish;
		end
		// a singular inverse still in flight could be shadowed; let the back end settle
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(7))
			0: v = MAXP;
			1: v = MAXN;
			2: v = 64'(signed'(v[39:0]));
			3: v = 64'(signed'(v[47:0]));
			default: ;
		endcase
		return v;
	endfunction

	function automatic stim_t rand_item();
		stim_t s;
		s.cmd = 1'($urandom_range(1));
		s.a = rand64();
		s.b = rand64();
		return s;
	endfunction

	// output side: random stalls, long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off) out_ch.ready <= 1'b0;
			else out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		xform_res_t w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				report("unexpected result", out_ch.out_a, '0);
			end else begin
				w = pending_results.pop_front();
				if (out_ch.out_a !== w.oa) report("out_a", out_ch.out_a, w.oa);
				if (out_ch.out_b !== w.ob) report("out_b", out_ch.out_b, w.ob);
				if (out_ch.singular !== w.sing) report("singular", 64'(out_ch.singular),
					64'(w.sing));
				if (w.sing) n_sing++;
			end
		end
	end

	row_t directed[$];

	task automatic add_row(input logic cmd, input logic [63:0] a, b, input logic known,
			input logic [63:0] oa, ob, input logic sing);
		row_t r;
		r.s = '{cmd: cmd, a: a, b: b};
		r.known = known;
		r.r = '{oa: oa, ob: ob, sing: sing};
		directed.insert(directed.size(), r);
	endtask

	initial begin
		int ph, k, cyc;
		in_ch.valid = 1'b0;
		in_ch.command = 1'b0;
		in_ch.coord_a = '0;
		in_ch.coord_b = '0;
		coef[REG_ORIGIN_X] = '0;
		coef[REG_PIXEL_WIDTH] = ONE;
		coef[REG_ROW_ROTATION] = '0;
		coef[REG_ORIGIN_Y] = '0;
		coef[REG_COLUMN_ROTATION] = '0;
		coef[REG_PIXEL_HEIGHT] = -ONE;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset coefficients: identity x, flipped y
		add_row(CMD_FWD, '0, '0, 1'b1, '0, '0, 1'b0);
		add_row(CMD_FWD, 3 * ONE, 5 * ONE, 1'b1, 3 * ONE, -5 * ONE, 1'b0);
		add_row(CMD_INV, 3 * ONE, 5 * ONE, 1'b1, 3 * ONE, -5 * ONE, 1'b0);
		add_row(CMD_FWD, MAXP, MAXN, 1'b1, MAXP, MAXP, 1'b0);
		add_row(CMD_INV, MAXN, MAXP, 1'b1, MAXN, -MAXP, 1'b0);
		add_row(CMD_FWD, 64'h8000_0000, 64'h7fff_ffff, 1'b0, '0, '0, 1'b0);
		add_row(CMD_INV, 64'hffff_ffff_8000_0000, 64'h1, 1'b0, '0, '0, 1'b0);
		add_row(CMD_FWD, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0, '0,
			1'b0);
		add_row(CMD_INV, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0, '0, '0,
			1'b0);
		foreach (directed[i]) send(directed[i].s, directed[i].known, directed[i].r);
		drain();

		// singular determinant right at the limit, then just above it
		load_coefs(ONE, 64'd18446744, '0, -ONE, '0, 64'd1);
		directed.delete();
		add_row(CMD_INV, 7 * ONE, 7 * ONE, 1'b1, '0, '0, 1'b1);
		add_row(CMD_FWD, ONE, ONE, 1'b0, '0, '0, 1'b0);
		foreach (directed[i]) send(directed[i].s, directed[i].known, directed[i].r);
		drain();
		reg_write(REG_PIXEL_WIDTH, 64'd18446745);
		send('{cmd: CMD_INV, a: 2 * ONE, b: '0}, 1'b0, '{default: '0});
		send('{cmd: CMD_INV, a: MAXP, b: MAXN}, 1'b0, '{default: '0});
		drain();
		// all zero gives singular, extreme coefficients saturate
		load_coefs('0, '0, '0, '0, '0, '0);
		send('{cmd: CMD_INV, a: ONE, b: ONE}, 1'b1, '{oa: '0, ob: '0, sing: 1'b1});
		send('{cmd: CMD_FWD, a: ONE, b: ONE}, 1'b1, '{oa: '0, ob: '0, sing: 1'b0});
		drain();
		load_coefs(MAXN, MAXP, MAXN, MAXP, MAXN, MAXP);
		send('{cmd: CMD_FWD, a: MAXP, b: MAXP}, 1'b0, '{default: '0});
		send('{cmd: CMD_INV, a: MAXN, b: MAXN}, 1'b0, '{default: '0});
		drain();

		// random phases with idling on each side and coefficient sets between them
		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			if (ph == 1) load_coefs(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
			else if (ph > 1)
				load_coefs(64'(signed'({$urandom, 8'h0})), 64'(signed'({$urandom, 4'h0})),
					64'(signed'($urandom)), 64'(signed'({$urandom, 8'h0})),
					64'(signed'($urandom)), 64'(signed'({$urandom, 4'h0})));
			for (k = 0; k < 155; k++) send(rand_item(), 1'b0, '{default: '0});
			if (ph == 4) begin
				// sender pauses until every result is back
				@(negedge clk);
				in_ch.valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			if (ph == 5) begin
				// long receiver hold-off while items keep coming until the input stalls
				hold_off = 1'b1;
				fork
					begin
						cyc = 0;
						while (cyc < 3000) begin
							@(posedge clk);
							cyc++;
						end
						hold_off = 1'b0;
					end
					for (int j = 0; j < 12; j++) send(rand_item(), 1'b0, '{default: '0});
				join
			end
			drain();
		end

		$display("covered %0d items (%0d inverse, %0d singular) across 8 idle/stall phases",
			n_items, n_inv, n_sing);
		$display("coefficient sets: reset, singular limit, zero, extremes, random");
		if (errors == 0) begin
			$display("PASS affine_pixel_world_transform");
		end else begin
			$display("FAIL affine_pixel_world_transform");
		end
		$finish;
	end
endmodule
